FILE: hdl/vmc_pkg.sv
// Shared constants for the vector magnitude clamp.
package vmc_pkg;
  localparam int unsigned DefComponentWidth = 16;
  localparam int unsigned CfgW              = 16;
  localparam logic [CfgW-1:0] CfgReset      = 16'd256;
endpackage

FILE: hdl/vector_magnitude_clamp_2d.sv
// Top level: clamps the length of a 2D fixed-point vector to a configured maximum.
// Pipeline from input transfer to result: three front stages (magnitude, products, compare),
//   one root cell and one divide cell per component bit, one output register.
// Throughput: one item per cycle; the whole chain holds while the output is stalled.
// Reset: rst_ni clears all valid bits and sets max_length to 1.0 (256).
module vector_magnitude_clamp_2d
  import vmc_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH = DefComponentWidth,
  localparam int unsigned CW    = COMPONENT_WIDTH,
  localparam int unsigned DW    = ((2 * CW + 7) / 8) * 8,
  localparam int unsigned SIDE_W = 2 * CW + 3,
  localparam int unsigned SQ_PASS_W = 4 * CW + SIDE_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i,     // max_length
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [DW-1:0]   s_axis_tdata,   // in_x, in_y
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [DW-1:0]   m_axis_tdata,   // out_x, out_y
  output logic            m_axis_tuser    // was_clamped
);
  logic [CfgW-1:0] max_len_q;
  logic            en;

  logic          v1_q;
  logic [CW-1:0] x1_q, y1_q, mx1_q, my1_q, m1_q;
  logic          nx1_q, ny1_q;
  logic [CW-1:0] in_x, in_y;

  logic             v2_q;
  logic [2*CW-1:0]  sqx2_q, sqy2_q, px2_q, py2_q, mm2_q;
  logic [2*CW-1:0]  side2_q;
  logic             nx2_q, ny2_q;

  logic             v3_q;
  logic [2*CW-1:0]  s3_q, px3_q, py3_q;
  logic [SIDE_W-1:0] side3_q;

  logic                 sv   [CW+1];
  logic [2*CW-1:0]      srad [CW+1];
  logic [CW:0]          srem [CW+1];
  logic [CW-1:0]        sroot[CW+1];
  logic [SQ_PASS_W-1:0] spass[CW+1];

  logic              dv   [CW+1];
  logic [CW-1:0]     dden [CW+1];
  logic [CW-1:0]     drx  [CW+1];
  logic [CW-1:0]     dry  [CW+1];
  logic [CW-1:0]     dlx  [CW+1];
  logic [CW-1:0]     dly  [CW+1];
  logic [CW-1:0]     dqx  [CW+1];
  logic [CW-1:0]     dqy  [CW+1];
  logic [SIDE_W-1:0] dpass[CW+1];

  logic              out_v_q, out_c_q;
  logic [CW-1:0]     out_x_q, out_y_q;
  logic [SIDE_W-1:0] fside;
  logic [CW-1:0]     fx, fy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= CfgReset;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign in_x          = s_axis_tdata[CW-1:0];
  assign in_y          = s_axis_tdata[2*CW-1:CW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= s_axis_tvalid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      out_v_q <= dv[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q    <= in_x;
      y1_q    <= in_y;
      nx1_q   <= in_x[CW-1];
      ny1_q   <= in_y[CW-1];
      mx1_q   <= in_x[CW-1] ? (~in_x + CW'(1)) : in_x;
      my1_q   <= in_y[CW-1] ? (~in_y + CW'(1)) : in_y;
      m1_q    <= CW'(max_len_q);
      sqx2_q  <= mx1_q * mx1_q;
      sqy2_q  <= my1_q * my1_q;
      px2_q   <= mx1_q * m1_q;
      py2_q   <= my1_q * m1_q;
      mm2_q   <= m1_q * m1_q;
      side2_q <= {y1_q, x1_q};
      nx2_q   <= nx1_q;
      ny2_q   <= ny1_q;
      s3_q    <= sqx2_q + sqy2_q;
      px3_q   <= px2_q;
      py3_q   <= py2_q;
      side3_q <= {(sqx2_q + sqy2_q) > mm2_q, ny2_q, nx2_q, side2_q};
    end
  end

  assign sv[0]    = v3_q;
  assign srad[0]  = s3_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign spass[0] = {py3_q, px3_q, side3_q};

  for (genvar i = 0; i < CW; i++) begin : g_sqrt
    vmc_sqrt_cell #(.CW(CW), .PASS_W(SQ_PASS_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sv[i]), .rad_i(srad[i]), .rem_i(srem[i]), .root_i(sroot[i]),
      .pass_i(spass[i]),
      .valid_o(sv[i+1]), .rad_o(srad[i+1]), .rem_o(srem[i+1]), .root_o(sroot[i+1]),
      .pass_o(spass[i+1])
    );
  end

  assign dv[0]    = sv[CW];
  assign dden[0]  = sroot[CW];
  assign drx[0]   = spass[CW][SIDE_W+2*CW-1 -: CW];
  assign dlx[0]   = spass[CW][SIDE_W+CW-1 -: CW];
  assign dry[0]   = spass[CW][SIDE_W+4*CW-1 -: CW];
  assign dly[0]   = spass[CW][SIDE_W+3*CW-1 -: CW];
  assign dqx[0]   = '0;
  assign dqy[0]   = '0;
  assign dpass[0] = spass[CW][SIDE_W-1:0];

  for (genvar i = 0; i < CW; i++) begin : g_div
    vmc_div_cell #(.CW(CW), .PASS_W(SIDE_W)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv[i]), .den_i(dden[i]), .remx_i(drx[i]), .remy_i(dry[i]),
      .lox_i(dlx[i]), .loy_i(dly[i]), .qx_i(dqx[i]), .qy_i(dqy[i]), .pass_i(dpass[i]),
      .valid_o(dv[i+1]), .den_o(dden[i+1]), .remx_o(drx[i+1]), .remy_o(dry[i+1]),
      .lox_o(dlx[i+1]), .loy_o(dly[i+1]), .qx_o(dqx[i+1]), .qy_o(dqy[i+1]),
      .pass_o(dpass[i+1])
    );
  end

  // side word: {clamp, ny, nx, y, x}
  assign fside = dpass[CW];
  assign fx = fside[2*CW] ? (~dqx[CW] + CW'(1)) : dqx[CW];
  assign fy = fside[2*CW+1] ? (~dqy[CW] + CW'(1)) : dqy[CW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_c_q <= fside[2*CW+2];
      out_x_q <= fside[2*CW+2] ? fx : fside[CW-1:0];
      out_y_q <= fside[2*CW+2] ? fy : fside[2*CW-1:CW];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = DW'({out_y_q, out_x_q});
  assign m_axis_tuser  = out_c_q;
endmodule

FILE: hdl/vmc_sqrt_cell.sv
// One bit of the integer square root: consumes two bits of the radicand per cycle while en_i is high.
module vmc_sqrt_cell
  import vmc_pkg::*;
#(
  parameter int unsigned CW     = DefComponentWidth,
  parameter int unsigned PASS_W = 4 * CW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*CW-1:0]   rad_i,
  input  logic [CW:0]       rem_i,
  input  logic [CW-1:0]     root_i,
  input  logic [PASS_W-1:0] pass_i,
  output logic              valid_o,
  output logic [2*CW-1:0]   rad_o,
  output logic [CW:0]       rem_o,
  output logic [CW-1:0]     root_o,
  output logic [PASS_W-1:0] pass_o
);
  logic [CW+2:0] rem2, trial, diff;
  logic          fits;
  logic          valid_q;
  logic [2*CW-1:0]   rad_q;
  logic [CW:0]       rem_q, rem_d;
  logic [CW-1:0]     root_q, root_d;
  logic [PASS_W-1:0] pass_q;

  always_comb begin
    rem2  = {rem_i, rad_i[2*CW-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    diff  = rem2 - trial;
    fits  = (rem2 >= trial);
    if (fits) begin
      rem_d  = diff[CW:0];
      root_d = {root_i[CW-2:0], 1'b1};
    end else begin
      rem_d  = rem2[CW:0];
      root_d = {root_i[CW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= {rad_i[2*CW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pass_o  = pass_q;
endmodule

FILE: hdl/vmc_div_cell.sv
// One quotient bit of restoring division for both components.
module vmc_div_cell
  import vmc_pkg::*;
#(
  parameter int unsigned CW     = DefComponentWidth,
  parameter int unsigned PASS_W = 2 * CW + 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [CW-1:0]     den_i,
  input  logic [CW-1:0]     remx_i,
  input  logic [CW-1:0]     remy_i,
  input  logic [CW-1:0]     lox_i,
  input  logic [CW-1:0]     loy_i,
  input  logic [CW-1:0]     qx_i,
  input  logic [CW-1:0]     qy_i,
  input  logic [PASS_W-1:0] pass_i,
  output logic              valid_o,
  output logic [CW-1:0]     den_o,
  output logic [CW-1:0]     remx_o,
  output logic [CW-1:0]     remy_o,
  output logic [CW-1:0]     lox_o,
  output logic [CW-1:0]     loy_o,
  output logic [CW-1:0]     qx_o,
  output logic [CW-1:0]     qy_o,
  output logic [PASS_W-1:0] pass_o
);
  logic [CW:0]   rx2, ry2, dext;
  logic          bx, by;
  logic [CW-1:0] remx_d, remy_d;
  logic          valid_q;
  logic [CW-1:0] den_q, remx_q, remy_q, lox_q, loy_q, qx_q, qy_q;
  logic [PASS_W-1:0] pass_q;

  always_comb begin
    dext   = {1'b0, den_i};
    rx2    = {remx_i, lox_i[CW-1]};
    ry2    = {remy_i, loy_i[CW-1]};
    bx     = (rx2 >= dext);
    by     = (ry2 >= dext);
    remx_d = bx ? CW'(rx2 - dext) : rx2[CW-1:0];
    remy_d = by ? CW'(ry2 - dext) : ry2[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q  <= den_i;
      remx_q <= remx_d;
      remy_q <= remy_d;
      lox_q  <= {lox_i[CW-2:0], 1'b0};
      loy_q  <= {loy_i[CW-2:0], 1'b0};
      qx_q   <= {qx_i[CW-2:0], bx};
      qy_q   <= {qy_i[CW-2:0], by};
      pass_q <= pass_i;
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign remx_o  = remx_q;
  assign remy_o  = remy_q;
  assign lox_o   = lox_q;
  assign loy_o   = loy_q;
  assign qx_o    = qx_q;
  assign qy_o    = qy_q;
  assign pass_o  = pass_q;
endmodule

FILE: hdl/vmc_checker.sv
// Port-level checks for the vector magnitude clamp, bound to the top level.
module vmc_checker
  import vmc_pkg::*;
#(
  parameter int unsigned DW = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          cfg_ready_o,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [DW-1:0] m_axis_tdata,
  input logic          m_axis_tuser
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output space");

  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid && cfg_ready_o)
    else $error("output valid during reset");
endmodule

bind vector_magnitude_clamp_2d vmc_checker #(.DW(DW)) u_vmc_checker (
  .clk_i, .rst_ni, .cfg_ready_o, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
